@@ rtl/stg_pkg.sv @@
package stg_pkg;

    typedef longint unsigned t_u64;

    localparam int CMD_W     = 2;
    localparam int FREQ_W    = 17;
    localparam int DUR_W     = 16;
    localparam int PCT_W     = 8;
    localparam int SMP_W     = 16;
    localparam int ST_W      = 2;
    localparam int RATE_W    = 18;
    localparam int LEVEL_W   = 7;
    localparam int MAG_W     = 15;

    localparam int RATE_RESET = 48000;
    localparam int PCT_FULL   = 100;
    localparam int FRAME_DIV  = 1000;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int TAIL_MS_DEF         = 30;
    localparam int PHASE_BITS_MAX      = 48;

    localparam logic [CMD_W-1:0] CMD_TONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SILENCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT    = 2'd1;
    localparam logic [ST_W-1:0] ST_IDLE_TICK = 2'd2;

    // serial multiplier: A x B, B consumed one bit per cycle
    localparam int MUL_A_W   = RATE_W;
    localparam int MUL_B_W   = DUR_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_SHORT = 7;
    localparam int SHORT_P_W = MUL_A_W + MUL_SHORT;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int DIV_CNT_W = $clog2(FREQ_W + PHASE_BITS_MAX + 1);

    localparam longint FR_MAX =
        (((longint'(1) << RATE_W) - 1) * ((longint'(1) << DUR_W) - 1)) / FRAME_DIV;
    localparam int FR_W = $clog2(FR_MAX + 1);

    localparam t_u64 HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] steps;
    } t_mul_ctl;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_ctl;

    // shift-subtract quotient, used only while building the table
    function automatic t_u64 udiv64(input t_u64 num, input t_u64 den);
        t_u64 q;
        t_u64 r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave entry: Q30 Taylor series of the angle, rounded to 15 bits
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned abits);
        t_u64   x;
        t_u64   term;
        longint sum;
        t_u64   scaled;
        x    = (t_u64'(k) * HALF_PI_Q30) >> abits;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv64(term, t_u64'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        scaled = (t_u64'(sum) * 64'd32767 + (t_u64'(1) << 29)) >> 30;
        return scaled[MAG_W-1:0];
    endfunction

endpackage

@@ rtl/stg_req_if.sv @@
interface stg_req_if;
    import stg_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [FREQ_W-1:0]  frequency_hz;
    logic [DUR_W-1:0]   duration_ms;
    logic [PCT_W-1:0]   amplitude_percent;

    modport source (output valid, cmd, frequency_hz, duration_ms, amplitude_percent,
                    input ready);
    modport sink (input valid, cmd, frequency_hz, duration_ms, amplitude_percent,
                  output ready);
endinterface

@@ rtl/stg_res_if.sv @@
interface stg_res_if;
    import stg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic [ST_W-1:0]         status;
    logic                    last_frame;

    modport source (output valid, sample, status, last_frame, input ready);
    modport sink (input valid, sample, status, last_frame, output ready);
endinterface

@@ rtl/stg_mul.sv @@
module stg_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stg_pkg::t_mul_ctl             i_ctl,
    input  logic [stg_pkg::MUL_A_W-1:0]   i_a,
    input  logic [stg_pkg::MUL_B_W-1:0]   i_b,
    output logic [stg_pkg::MUL_P_W-1:0]   o_prod,
    output logic                          o_done
);
    import stg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_P_W-1:0]   r_p;
    logic [MUL_A_W:0]     n_sum;

    // shift-add, product forms from the top down as B shifts out the bottom
    assign n_sum = {1'b0, r_p[MUL_P_W-1:MUL_B_W]}
                 + (r_p[0] ? {1'b0, r_a} : {(MUL_A_W + 1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
                r_a    <= i_a;
                r_p    <= {{MUL_A_W{1'b0}}, i_b};
            end else if (r_busy) begin
                r_p   <= {n_sum, r_p[MUL_B_W-1:1]};
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_p;
    assign o_done = r_done;
endmodule

@@ rtl/stg_div.sv @@
module stg_div #(
    parameter int DV_W = 49
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stg_pkg::t_div_ctl            i_ctl,
    input  logic [DV_W-1:0]              i_num,
    input  logic [stg_pkg::RATE_W-1:0]   i_den,
    output logic [DV_W-1:0]              o_quot,
    output logic                         o_done
);
    import stg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DV_W-1:0]      r_num;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_den;
    logic [RATE_W:0]      n_try;
    logic [RATE_W:0]      n_diff;
    logic                 n_ge;

    // restoring division, one quotient bit per cycle; dividend is left aligned
    assign n_try  = {r_rem, r_num[DV_W-1]};
    assign n_diff = n_try - {1'b0, r_den};
    assign n_ge   = (n_try >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
                r_num  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[RATE_W-1:0] : n_try[RATE_W-1:0];
                r_num <= {r_num[DV_W-2:0], n_ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_num;
    assign o_done = r_done;
endmodule

@@ rtl/stg_rom.sv @@
module stg_rom #(
    parameter int ADDR_BITS = 10
) (
    input  logic                        i_clk,
    input  logic [ADDR_BITS:0]          i_addr,
    output logic [stg_pkg::MAG_W-1:0]   o_data
);
    import stg_pkg::*;

    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    logic [MAG_W-1:0] w_tab [0:DEPTH-1];
    logic [MAG_W-1:0] r_data;

    for (genvar k = 0; k < DEPTH; k++) begin : g_tab
        localparam logic [MAG_W-1:0] VAL = sine_entry(k, ADDR_BITS);
        assign w_tab[k] = VAL;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;
endmodule

@@ rtl/sine_tone_generator_unit.sv @@
// channel  | modport | payload                                          | handshake
// i_req    | sink    | cmd, frequency_hz, duration_ms, amplitude_percent | valid/ready
// o_res    | source  | sample, status, last_frame                        | valid/ready
// i_cfg_*  | -       | sample_rate (18 bits)                             | write enable
//
// One request at a time; a serial multiplier and a serial restoring divider do the math,
// one bit per cycle. Tone tick: 7 multiply + 25 divide steps. Start silence and start
// tone both use the multiplier and divider; in a start tone the phase-step divide takes
// 17 + PHASE_BITS steps. Other requests use neither and go straight to the result.
// Synchronous active-low reset; the result register lets the next request in while
// a result waits, and a stalled result holds the block in its final state.
module sine_tone_generator_unit #(
    parameter int PHASE_BITS      = stg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int TAIL_MS         = stg_pkg::TAIL_MS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [stg_pkg::RATE_W-1:0]  i_cfg_data,
    stg_req_if.sink                     i_req,
    stg_res_if.source                   o_res
);
    import stg_pkg::*;

    localparam int     ST_N     = FREQ_W + PHASE_BITS;
    localparam int     DV_W     = (ST_N > MUL_P_W) ? ST_N : MUL_P_W;
    localparam longint TAIL_MAX = (longint'((1 << RATE_W) - 1) * TAIL_MS) / FRAME_DIV;
    localparam int     TAIL_W   = (TAIL_MAX > 0) ? $clog2(TAIL_MAX + 1) : 1;
    localparam logic [TABLE_ADDR_BITS:0] TAB_N = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_FR_MUL,
        S_FR_DIV,
        S_TL_MUL,
        S_TL_DIV,
        S_ST_DIV,
        S_ROM,
        S_SM_MUL,
        S_SM_DIV,
        S_PUT
    } t_state;

    t_state                r_state;
    logic [RATE_W-1:0]     r_rate;
    logic [CMD_W-1:0]      r_cmd;
    logic [FREQ_W-1:0]     r_freq;
    logic [PCT_W-1:0]      r_pct;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_inc;
    logic [FR_W-1:0]       r_tone;
    logic [TAIL_W-1:0]     r_tail;
    logic [LEVEL_W-1:0]    r_level;
    logic [FR_W-1:0]       r_new_fr;
    logic [TAIL_W-1:0]     r_new_tl;

    t_mul_ctl              r_mul_ctl;
    logic [MUL_A_W-1:0]    r_mul_a;
    logic [MUL_B_W-1:0]    r_mul_b;
    t_div_ctl              r_div_ctl;
    logic [DV_W-1:0]       r_div_num;
    logic [RATE_W-1:0]     r_div_den;

    logic [SMP_W-1:0]      r_p_sample;
    logic [ST_W-1:0]       r_p_status;
    logic                  r_p_last;
    logic                  r_valid;
    logic [SMP_W-1:0]      r_sample;
    logic [ST_W-1:0]       r_status;
    logic                  r_last;

    logic [MUL_P_W-1:0]          w_mul_prod;
    logic                        w_mul_done;
    logic [DV_W-1:0]             w_div_quot;
    logic                        w_div_done;
    logic [MAG_W-1:0]            w_rom_data;
    logic [TABLE_ADDR_BITS+1:0]  w_top;
    logic [TABLE_ADDR_BITS:0]    w_rom_addr;
    logic [SHORT_P_W-1:0]        w_short;
    logic [SMP_W-1:0]            w_mag;
    logic [LEVEL_W-1:0]          w_sat;

    assign w_top      = r_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS + 2];
    assign w_rom_addr = w_top[TABLE_ADDR_BITS]
                      ? (TAB_N - {1'b0, w_top[TABLE_ADDR_BITS-1:0]})
                      : {1'b0, w_top[TABLE_ADDR_BITS-1:0]};
    assign w_short    = w_mul_prod[MUL_P_W-1:MUL_B_W-MUL_SHORT];
    assign w_mag      = {1'b0, w_div_quot[MAG_W-1:0]};
    assign w_sat      = (r_pct > PCT_W'(PCT_FULL)) ? LEVEL_W'(PCT_FULL) : r_pct[LEVEL_W-1:0];

    stg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_mul_ctl),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_prod  (w_mul_prod),
        .o_done  (w_mul_done)
    );

    stg_div #(.DV_W(DV_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_div_ctl),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_quot  (w_div_quot),
        .o_done  (w_div_done)
    );

    stg_rom #(.ADDR_BITS(TABLE_ADDR_BITS)) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rate    <= RATE_W'(RATE_RESET);
            r_phase   <= '0;
            r_inc     <= '0;
            r_tone    <= '0;
            r_tail    <= '0;
            r_level   <= '0;
            r_mul_ctl <= '0;
            r_div_ctl <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_mul_ctl.start <= 1'b0;
            r_div_ctl.start <= 1'b0;
            if (i_cfg_we) begin
                r_rate <= i_cfg_data;
            end
            if (r_valid && o_res.ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd      <= i_req.cmd;
                        r_freq     <= i_req.frequency_hz;
                        r_pct      <= i_req.amplitude_percent;
                        r_p_sample <= '0;
                        r_p_status <= ST_OK;
                        r_p_last   <= 1'b0;
                        case (i_req.cmd) inside
                            CMD_TONE, CMD_SILENCE: begin
                                if (r_rate == '0 || (i_req.cmd == CMD_TONE &&
                                                     i_req.frequency_hz == '0)) begin
                                    r_p_status <= ST_REJECT;
                                    r_state    <= S_PUT;
                                end else begin
                                    r_mul_ctl <= '{start: 1'b1,
                                                   steps: MUL_CNT_W'(MUL_B_W)};
                                    r_mul_a   <= r_rate;
                                    r_mul_b   <= i_req.duration_ms;
                                    r_state   <= S_FR_MUL;
                                end
                            end
                            CMD_TICK: begin
                                if (r_tone != '0) begin
                                    r_state <= S_ROM;
                                end else if (r_tail != '0) begin
                                    r_tail   <= r_tail - TAIL_W'(1);
                                    r_p_last <= (r_tail == TAIL_W'(1));
                                    r_state  <= S_PUT;
                                end else begin
                                    r_p_status <= ST_IDLE_TICK;
                                    r_state    <= S_PUT;
                                end
                            end
                            default: begin
                                r_state <= S_PUT;
                            end
                        endcase
                    end
                end
                S_FR_MUL: begin
                    if (w_mul_done) begin
                        r_div_ctl <= '{start: 1'b1, steps: DIV_CNT_W'(MUL_P_W)};
                        r_div_num <= DV_W'(w_mul_prod) << (DV_W - MUL_P_W);
                        r_div_den <= RATE_W'(FRAME_DIV);
                        r_state   <= S_FR_DIV;
                    end
                end
                S_FR_DIV: begin
                    if (w_div_done) begin
                        if (r_cmd == CMD_SILENCE) begin
                            r_phase <= '0;
                            r_inc   <= '0;
                            r_level <= '0;
                            r_tail  <= '0;
                            r_tone  <= w_div_quot[FR_W-1:0];
                            r_state <= S_PUT;
                        end else begin
                            r_new_fr  <= w_div_quot[FR_W-1:0];
                            r_mul_ctl <= '{start: 1'b1, steps: MUL_CNT_W'(MUL_SHORT)};
                            r_mul_a   <= r_rate;
                            r_mul_b   <= MUL_B_W'(TAIL_MS);
                            r_state   <= S_TL_MUL;
                        end
                    end
                end
                S_TL_MUL: begin
                    if (w_mul_done) begin
                        r_div_ctl <= '{start: 1'b1, steps: DIV_CNT_W'(SHORT_P_W)};
                        r_div_num <= DV_W'(w_short) << (DV_W - SHORT_P_W);
                        r_div_den <= RATE_W'(FRAME_DIV);
                        r_state   <= S_TL_DIV;
                    end
                end
                S_TL_DIV: begin
                    if (w_div_done) begin
                        r_new_tl  <= w_div_quot[TAIL_W-1:0];
                        r_div_ctl <= '{start: 1'b1, steps: DIV_CNT_W'(ST_N)};
                        r_div_num <= DV_W'({r_freq, {PHASE_BITS{1'b0}}}) << (DV_W - ST_N);
                        r_div_den <= r_rate;
                        r_state   <= S_ST_DIV;
                    end
                end
                S_ST_DIV: begin
                    if (w_div_done) begin
                        r_phase <= '0;
                        r_inc   <= w_div_quot[PHASE_BITS-1:0];
                        r_level <= w_sat;
                        r_tail  <= r_new_tl;
                        r_tone  <= r_new_fr;
                        r_state <= S_PUT;
                    end
                end
                S_ROM: begin
                    r_mul_ctl <= '{start: 1'b1, steps: MUL_CNT_W'(MUL_SHORT)};
                    r_mul_a   <= MUL_A_W'(w_rom_data);
                    r_mul_b   <= MUL_B_W'(r_level);
                    r_state   <= S_SM_MUL;
                end
                S_SM_MUL: begin
                    if (w_mul_done) begin
                        r_div_ctl <= '{start: 1'b1, steps: DIV_CNT_W'(SHORT_P_W)};
                        r_div_num <= DV_W'(w_short) << (DV_W - SHORT_P_W);
                        r_div_den <= RATE_W'(PCT_FULL);
                        r_state   <= S_SM_DIV;
                    end
                end
                S_SM_DIV: begin
                    if (w_div_done) begin
                        r_p_sample <= r_phase[PHASE_BITS-1] ? (SMP_W'(0) - w_mag) : w_mag;
                        r_phase    <= r_phase + r_inc;
                        r_tone     <= r_tone - FR_W'(1);
                        r_p_last   <= (r_tone == FR_W'(1)) && (r_tail == '0);
                        r_state    <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_valid || o_res.ready) begin
                        r_valid  <= 1'b1;
                        r_sample <= r_p_sample;
                        r_status <= r_p_status;
                        r_last   <= r_p_last;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_valid;
    assign o_res.sample     = r_sample;
    assign o_res.status     = r_status;
    assign o_res.last_frame = r_last;
endmodule

@@ tb/stg_frame_checker.sv @@
`timescale 1ns / 1ps

module stg_frame_checker
    import stg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [RATE_W-1:0] i_cfg_data,
    stg_req_if                i_req,
    stg_res_if                i_res,
    output int                o_errors,
    output int                o_pending,
    output int                o_ends,
    output int                o_rejects,
    output int                o_idles
);

    localparam int PB  = PHASE_BITS_DEF;
    localparam int TAB = TABLE_ADDR_BITS_DEF;
    localparam int N   = 1 << TAB;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [ST_W-1:0]         status;
        logic                    last_frame;
    } frame_t;

    logic [MAG_W-1:0]   sine_quarter [0:N];
    logic [RATE_W-1:0]  rate;
    logic [PB-1:0]      phase;
    logic [PB-1:0]      step;
    logic [33:0]        tone_left;
    logic [31:0]        tail_left;
    logic [LEVEL_W-1:0] level;
    frame_t             frames_due [$];
    int                 n_err;
    int                 n_end;
    int                 n_rej;
    int                 n_idle;

    // Taylor series in Q30; odd and even terms summed apart, then clamped to [0, 1]
    function automatic logic [MAG_W-1:0] quarter_sine_mag(input int unsigned k);
        t_u64 ang;
        t_u64 pw;
        t_u64 pos;
        t_u64 neg;
        t_u64 d;
        ang = (t_u64'(k) * HALF_PI_Q30) >> TAB;
        pw  = ang;
        pos = ang;
        neg = 0;
        for (int n = 1; n <= 7; n++) begin
            pw = (pw * ang) >> 30;
            pw = (pw * ang) >> 30;
            pw = pw / t_u64'(2 * n * (2 * n + 1));
            if (n % 2 == 1) begin
                neg = neg + pw;
            end else begin
                pos = pos + pw;
            end
        end
        d = (neg > pos) ? t_u64'(0) : pos - neg;
        if (d > (t_u64'(1) << 30)) begin
            d = t_u64'(1) << 30;
        end
        d = (d * 64'd32767 + (t_u64'(1) << 29)) >> 30;
        return d[MAG_W-1:0];
    endfunction

    function automatic frame_t next_frame(input logic [CMD_W-1:0]  c,
                                          input logic [FREQ_W-1:0] f,
                                          input logic [DUR_W-1:0]  d,
                                          input logic [PCT_W-1:0]  p);
        frame_t               r;
        logic [FREQ_W+PB-1:0] quo;
        logic [TAB+1:0]       addr;
        logic [TAB-1:0]       idx;
        logic [MAG_W-1:0]     mag;
        logic [31:0]          v;
        r = '0;
        case (c)
            CMD_TONE, CMD_SILENCE: begin
                if (rate == 0 || (c == CMD_TONE && f == 0)) begin
                    r.status = ST_REJECT;
                end else begin
                    phase     = '0;
                    tone_left = 34'((t_u64'(rate) * d) / FRAME_DIV);
                    if (c == CMD_TONE) begin
                        quo       = {f, {PB{1'b0}}} / rate;
                        step      = quo[PB-1:0];
                        level     = (p > PCT_FULL) ? LEVEL_W'(PCT_FULL) : p[LEVEL_W-1:0];
                        tail_left = 32'((t_u64'(rate) * TAIL_MS_DEF) / FRAME_DIV);
                    end else begin
                        step      = '0;
                        level     = '0;
                        tail_left = '0;
                    end
                end
            end
            CMD_TICK: begin
                if (tone_left != 0) begin
                    addr = phase[PB-1 -: TAB+2];
                    idx  = addr[TAB-1:0];
                    mag  = addr[TAB] ? sine_quarter[N - idx] : sine_quarter[idx];
                    v    = (32'(mag) * level) / PCT_FULL;
                    if (addr[TAB+1]) begin
                        v = -v;
                    end
                    r.sample     = v[SMP_W-1:0];
                    phase        = phase + step;
                    tone_left    = tone_left - 1;
                    r.last_frame = (tone_left == 0 && tail_left == 0);
                end else if (tail_left != 0) begin
                    tail_left    = tail_left - 1;
                    r.last_frame = (tail_left == 0);
                end else begin
                    r.status = ST_IDLE_TICK;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    initial begin
        for (int k = 0; k <= N; k++) begin
            sine_quarter[k] = quarter_sine_mag(k);
        end
    end

    always @(posedge i_clk) begin
        frame_t want;
        if (!i_rst_n) begin
            rate      = RATE_W'(RATE_RESET);
            phase     = '0;
            step      = '0;
            tone_left = '0;
            tail_left = '0;
            level     = '0;
            frames_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (frames_due.size() == 0) begin
                    $error("result with no request outstanding");
                    n_err++;
                end else begin
                    want = frames_due.pop_front();
                    if (i_res.sample !== want.sample) begin
                        $error("sample: expected %0d, got %0d", want.sample, i_res.sample);
                        n_err++;
                    end
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        n_err++;
                    end
                    if (i_res.last_frame !== want.last_frame) begin
                        $error("last_frame: expected %0d, got %0d",
                               want.last_frame, i_res.last_frame);
                        n_err++;
                    end
                    n_end  += want.last_frame;
                    n_rej  += (want.status == ST_REJECT);
                    n_idle += (want.status == ST_IDLE_TICK);
                end
            end
            if (i_req.valid && i_req.ready) begin
                frames_due.push_back(next_frame(i_req.cmd, i_req.frequency_hz,
                                                i_req.duration_ms, i_req.amplitude_percent));
            end
            if (i_cfg_we) begin
                rate = i_cfg_data;
            end
        end
        o_pending <= frames_due.size();
        o_errors  <= n_err;
        o_ends    <= n_end;
        o_rejects <= n_rej;
        o_idles   <= n_idle;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import stg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
    localparam int SPLIT     = 550;
    localparam int LIMIT     = 2_000_000;
    localparam int SETTLE    = 400;
    localparam int RUN_CAP   = 80;
    localparam int FREQ_TOP  = (1 << FREQ_W) - 1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [RATE_W-1:0] cfg_data;
    int                err_count;
    int                pending;
    int                n_ends;
    int                n_rejects;
    int                n_idles;
    int                n_sent;
    int                n_rates;
    int                cycles = 0;

    stg_req_if req ();
    stg_res_if res ();

    always #4 clk = ~clk;

    sine_tone_generator_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req),
        .o_res      (res)
    );

    stg_frame_checker u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req),
        .i_res      (res),
        .o_errors   (err_count),
        .o_pending  (pending),
        .o_ends     (n_ends),
        .o_rejects  (n_rejects),
        .o_idles    (n_idles)
    );

    // busy sender / slow receiver, then the reverse, then full rate
    function automatic int gap_pct(input bit sender);
        if (n_sent < SPLIT) begin
            return sender ? 22 : 72;
        end
        if (n_sent < 2 * SPLIT) begin
            return sender ? 72 : 22;
        end
        return 0;
    endfunction

    task automatic send_req(input logic [CMD_W-1:0]  c,
                            input logic [FREQ_W-1:0] f,
                            input logic [DUR_W-1:0]  d,
                            input logic [PCT_W-1:0]  p);
        while ($urandom_range(99) < gap_pct(1'b1)) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid             <= 1'b1;
        req.cmd               <= c;
        req.frequency_hz      <= f;
        req.duration_ms       <= d;
        req.amplitude_percent <= p;
        @(posedge clk);
        while (!req.ready) begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    task automatic tick();
        send_req(CMD_TICK, FREQ_W'($urandom), DUR_W'($urandom), PCT_W'($urandom));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
    endtask

    task automatic write_rate(input int r);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= RATE_W'(r);
        @(posedge clk);
        cfg_we   <= 1'b0;
        n_rates++;
    endtask

    task automatic run_phase(input int r, input int n_items, input int dur_max);
        int               done;
        int               ticks;
        longint           run_len;
        logic [CMD_W-1:0] c;
        logic [DUR_W-1:0] d;
        write_rate(r);
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(99) < 80) begin
                c = ($urandom_range(4) == 0) ? CMD_SILENCE : CMD_TONE;
                d = DUR_W'($urandom_range(0, dur_max));
                if ($urandom_range(1) == 1 && r >= 2) begin
                    send_req(c, FREQ_W'($urandom_range(1, r / 2)), d,
                             PCT_W'($urandom_range(0, 255)));
                end else begin
                    send_req(c, FREQ_W'($urandom_range(1, FREQ_TOP)), d,
                             PCT_W'($urandom_range(0, 255)));
                end
                done++;
                run_len = (longint'(r) * d) / FRAME_DIV;
                if (c == CMD_TONE) begin
                    run_len += (longint'(r) * TAIL_MS_DEF) / FRAME_DIV;
                end
                if (run_len > RUN_CAP) begin
                    run_len = RUN_CAP;
                end
                // now and then cut the run short so the next start replaces it
                if ($urandom_range(9) == 0) begin
                    ticks = $urandom_range(0, int'(run_len));
                end else begin
                    ticks = int'(run_len) + $urandom_range(0, 2);
                end
                for (int i = 0; i < ticks && done < n_items; i++) begin
                    tick();
                    done++;
                end
            end else begin
                c = CMD_W'($urandom_range(0, 3));
                send_req(c, FREQ_W'($urandom), DUR_W'($urandom), PCT_W'($urandom));
                if (c != CMD_UNDEF) begin
                    done++;
                end
            end
        end
    endtask

    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge clk);
            res.ready <= ($urandom_range(99) >= gap_pct(1'b0));
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        n_sent                = 0;
        n_rates               = 0;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_data              <= '0;
        req.valid             <= 1'b0;
        req.cmd               <= CMD_TICK;
        req.frequency_hz      <= '0;
        req.duration_ms       <= '0;
        req.amplitude_percent <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        tick();
        send_req(CMD_UNDEF, FREQ_W'(FREQ_TOP), 16'hFFFF, 8'hFF);
        send_req(CMD_TONE, FREQ_W'(0), DUR_W'(100), PCT_W'(50));
        send_req(CMD_TONE, FREQ_W'(1000), DUR_W'(1), PCT_W'(255));
        repeat (3) tick();
        // quarter-turn step lands on every quadrant edge
        send_req(CMD_TONE, FREQ_W'(12000), DUR_W'(1), PCT_W'(100));
        repeat (5) tick();
        // step wraps to zero, tail only
        send_req(CMD_TONE, FREQ_W'(96000), DUR_W'(0), PCT_W'(101));
        tick();
        send_req(CMD_TONE, FREQ_W'(FREQ_TOP), 16'hFFFF, PCT_W'(0));
        repeat (2) tick();
        send_req(CMD_SILENCE, FREQ_W'(0), DUR_W'(0), PCT_W'(255));
        tick();
        send_req(CMD_SILENCE, FREQ_W'(FREQ_TOP), DUR_W'(1), PCT_W'(77));
        tick();
        send_req(CMD_TONE, FREQ_W'(1), 16'hFFFF, PCT_W'(99));
        tick();

        run_phase(0, 60, 65535);
        run_phase(192000, 150, 65535);
        run_phase(1, 150, 40000);
        run_phase(100, 350, 400);
        run_phase(1000, 350, 30);
        run_phase(777, 300, 50);
        run_phase(48000, 250, 65535);

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d requests over %0d sample-rate settings (0 to 192000).",
                 n_sent, n_rates);
        $display("Checked %0d run endings, %0d rejected starts, %0d ticks while idle.",
                 n_ends, n_rejects, n_idles);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
